### design/bcop_pkg.sv
// bcop_pkg: shared types and constants of the binomial call option pricer
// no dependencies; imported by the controller, the datapath and the top level
package bcop_pkg;

	localparam int PRICE_W = 32;
	localparam int RATE_W  = 31;
	localparam int STEP_W  = 7;
	localparam int CFG_AW  = 2;

	// configuration register indexes
	localparam logic [CFG_AW-1:0] CFG_UP    = 2'd0;
	localparam logic [CFG_AW-1:0] CFG_DOWN  = 2'd1;
	localparam logic [CFG_AW-1:0] CFG_RATE  = 2'd2;
	localparam logic [CFG_AW-1:0] CFG_STEPS = 2'd3;

	// configuration reset values
	localparam logic signed [RATE_W-1:0] UP_RST    = 31'sd53687091;
	localparam logic signed [RATE_W-1:0] DOWN_RST  = -31'sd64424509;
	localparam logic signed [RATE_W-1:0] RATE_RST  = 31'sd10737418;
	localparam logic [STEP_W-1:0]        STEPS_RST = 7'd1;

	// multiplier operand selects
	localparam logic [1:0] MUL_DOWN = 2'd0;
	localparam logic [1:0] MUL_UP   = 2'd1;
	localparam logic [1:0] MUL_P    = 2'd2;
	localparam logic [1:0] MUL_Q    = 2'd3;

	// divider modes
	localparam logic DIV_P    = 1'b0;
	localparam logic DIV_NODE = 1'b1;

	localparam logic [PRICE_W-1:0] PRICE_MAX = 32'hFFFF_FFFF;

	// commands from controller to datapath
	typedef struct packed {
		logic       load_in;
		logic       div_start;
		logic       div_mode;
		logic       p_load;
		logic       s_init;
		logic       mul_go;
		logic [1:0] mul_sel;
		logic       s_update;
		logic       mem_we;
		logic       wr_payoff;
		logic       lo_load;
		logic       hi_load;
		logic       lo_shift;
		logic       t1_load;
		logic       sum_load;
		logic       node_fix;
		logic       node_quot;
		logic       out_load;
	} bcop_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic invalid;
		logic div_done;
		logic need_div;
	} bcop_sts_t;

endpackage

### design/bcop_div.sv
// bcop_div: restoring divider, one quotient bit per cycle
// no package dependency; used by bcop_datapath
module bcop_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [30:0] rem0,
	input  logic [63:0] dq0,
	input  logic [30:0] divisor,
	input  logic [6:0]  count,
	output logic        done,
	output logic [63:0] quot
);

	logic [6:0]  cnt_q;
	logic        done_q;
	logic [30:0] rem_q;
	logic [63:0] dq_q;
	logic [31:0] trial;
	logic        ge;
	logic [31:0] diff;

	// one trial subtraction
	assign trial = {rem_q, dq_q[63]};
	assign ge    = trial >= {1'b0, divisor};
	assign diff  = trial - {1'b0, divisor};

	// iteration count and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= count;
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 7'd1;
			done_q <= (cnt_q == 7'd1);
		end else begin
			done_q <= 1'b0;
		end
	end

	// partial remainder and dividend/quotient shifter
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem0;
			dq_q  <= dq0;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[30:0] : trial[30:0];
			dq_q  <= {dq_q[62:0], ge};
		end
	end

	assign done = done_q;
	assign quot = dq_q;

endmodule

### design/bcop_datapath.sv
// bcop_datapath: configuration registers, shared multiplier, divider and node store
// depends on bcop_pkg and bcop_div
module bcop_datapath #(
	parameter int MAX_STEPS = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [bcop_pkg::CFG_AW-1:0]     cfg_addr,
	input  logic [bcop_pkg::RATE_W-1:0]     cfg_data,
	input  logic [2*bcop_pkg::PRICE_W-1:0]  in_data,
	input  bcop_pkg::bcop_cmd_t             cmd,
	input  logic [$clog2(MAX_STEPS+1)-1:0]  addr,
	output bcop_pkg::bcop_sts_t             sts,
	output logic [$clog2(MAX_STEPS+1)-1:0]  t_steps,
	output logic [bcop_pkg::PRICE_W-1:0]    option_price,
	output logic                            status
);
	import bcop_pkg::*;

	localparam int AW = $clog2(MAX_STEPS + 1);
	localparam int CW = (AW > STEP_W) ? AW : STEP_W;

	logic signed [RATE_W-1:0] up_q, down_q, rate_q;
	logic [STEP_W-1:0]        steps_q;

	logic [31:0] s0_q, k_q, s_q, lo_q, hi_q, v_q, rd_q, option_q;
	logic        status_q;
	logic [31:0] p_mag_q, q_mag_q;
	logic        p_neg_q, q_neg_q;
	logic [63:0] prod_q;
	logic [34:0] t1_q;
	logic [35:0] sum_q;
	logic [31:0] node_mem [MAX_STEPS+1];

	logic [31:0] one_d_w, one_u_w, g_w, rd_diff, ud_diff;
	logic        rd_neg;
	logic [31:0] rd_mag_w;
	logic [CW-1:0] sc_w, max_w;
	logic [63:0] qd;
	logic        div_done;
	logic        div_start;
	logic [30:0] div_rem0, div_d;
	logic [63:0] div_dq0;
	logic [6:0]  div_cnt;
	logic [31:0] pmag_c;
	logic [33:0] p_s, q_s, q_abs;
	logic [31:0] mul_a, mul_b;
	logic [33:0] wmag, scaled;
	logic        term_neg;
	logic [34:0] term_c;
	logic        sum_pos;
	logic [32:0] su;
	logic [32:0] four_g;
	logic [31:0] payoff, wdata;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_q    <= UP_RST;
			down_q  <= DOWN_RST;
			rate_q  <= RATE_RST;
			steps_q <= STEPS_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_UP:    up_q    <= cfg_data;
				CFG_DOWN:  down_q  <= cfg_data;
				CFG_RATE:  rate_q  <= cfg_data;
				CFG_STEPS: steps_q <= cfg_data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	// rate terms: 1+d, 1+u, 1+r, r-d, u-d
	assign one_d_w  = {down_q[30], down_q} + 32'h4000_0000;
	assign one_u_w  = {up_q[30], up_q} + 32'h4000_0000;
	assign g_w      = {rate_q[30], rate_q} + 32'h4000_0000;
	assign rd_diff  = {rate_q[30], rate_q} - {down_q[30], down_q};
	assign ud_diff  = {up_q[30], up_q} - {down_q[30], down_q};
	assign rd_neg   = rd_diff[31];
	assign rd_mag_w = rd_neg ? (32'd0 - rd_diff) : rd_diff;

	// clamped step count
	assign sc_w    = CW'(steps_q);
	assign max_w   = CW'(MAX_STEPS);
	assign t_steps = (sc_w > max_w) ? max_w[AW-1:0] : sc_w[AW-1:0];

	// input capture
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			s0_q <= in_data[31:0];
			k_q  <= in_data[63:32];
		end
	end

	// divider operands
	always_comb begin
		if (cmd.div_mode == DIV_NODE) begin
			div_rem0 = su[32:2];
			div_dq0  = {su[1:0], 62'd0};
			div_d    = g_w[30:0];
			div_cnt  = 7'd32;
		end else begin
			div_rem0 = '0;
			div_dq0  = {3'd0, rd_mag_w[30:0], 30'd0};
			div_d    = ud_diff[30:0];
			div_cnt  = 7'd64;
		end
	end

	assign div_start = cmd.div_start;

	bcop_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.rem0    (div_rem0),
		.dq0     (div_dq0),
		.divisor (div_d),
		.count   (div_cnt),
		.done    (div_done),
		.quot    (qd)
	);

	// p saturated, q = 1 - p
	always_comb begin
		if (rd_neg)
			pmag_c = (qd > 64'h8000_0000) ? 32'h8000_0000 : qd[31:0];
		else
			pmag_c = (qd > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : qd[31:0];
		p_s   = rd_neg ? (34'd0 - {2'b00, pmag_c}) : {2'b00, pmag_c};
		q_s   = 34'h4000_0000 - p_s;
		q_abs = q_s[33] ? (34'd0 - q_s) : q_s;
	end

	always_ff @(posedge clk) begin
		if (cmd.p_load) begin
			p_mag_q <= pmag_c;
			p_neg_q <= rd_neg;
			q_mag_q <= q_abs[31:0];
			q_neg_q <= q_s[33];
		end
	end

	// shared multiplier with registered product
	always_comb begin
		case (cmd.mul_sel)
			MUL_DOWN: begin mul_a = s_q;     mul_b = {1'b0, one_d_w[30:0]}; end
			MUL_UP:   begin mul_a = s_q;     mul_b = {1'b0, one_u_w[30:0]}; end
			MUL_P:    begin mul_a = p_mag_q; mul_b = hi_q; end
			MUL_Q:    begin mul_a = q_mag_q; mul_b = lo_q; end
			default:  begin mul_a = s_q;     mul_b = {1'b0, one_d_w[30:0]}; end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_go)
			prod_q <= mul_a * mul_b;
	end

	// leaf price update, saturated
	assign scaled = prod_q[63:30];

	always_ff @(posedge clk) begin
		if (cmd.s_init)
			s_q <= s0_q;
		else if (cmd.s_update)
			s_q <= (scaled[33:32] != 2'b00) ? PRICE_MAX : scaled[31:0];
	end

	// signed weighted terms and their sum
	assign wmag     = prod_q[63:30];
	assign term_neg = cmd.t1_load ? p_neg_q : q_neg_q;
	assign term_c   = term_neg ? (35'd0 - {1'b0, wmag}) : {1'b0, wmag};

	always_ff @(posedge clk) begin
		if (cmd.t1_load)
			t1_q <= term_c;
		if (cmd.sum_load)
			sum_q <= {t1_q[34], t1_q} + {term_c[34], term_c};
	end

	// node special cases
	assign sum_pos = !sum_q[35] && (sum_q != 36'd0);
	assign su      = (sum_q[35:33] != 3'd0) ? 33'h1_FFFF_FFFF : sum_q[32:0];
	assign four_g  = {g_w[30:0], 2'b00};

	assign sts.invalid  = (up_q <= down_q);
	assign sts.div_done = div_done;
	assign sts.need_div = sum_pos && (g_w[30:0] != 31'd0) && (su < four_g);

	always_ff @(posedge clk) begin
		if (cmd.node_fix)
			v_q <= sum_pos ? PRICE_MAX : 32'd0;
		else if (cmd.node_quot)
			v_q <= qd[31:0];
	end

	// node store
	assign payoff = (s_q > k_q) ? (s_q - k_q) : 32'd0;
	assign wdata  = cmd.wr_payoff ? payoff : v_q;

	always_ff @(posedge clk) begin
		if (cmd.mem_we)
			node_mem[addr] <= wdata;
		rd_q <= node_mem[addr];
	end

	// neighbor registers for the rollback
	always_ff @(posedge clk) begin
		if (cmd.lo_load)
			lo_q <= rd_q;
		else if (cmd.lo_shift)
			lo_q <= hi_q;
		if (cmd.hi_load)
			hi_q <= rd_q;
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			option_q <= sts.invalid ? 32'd0 : rd_q;
			status_q <= sts.invalid;
		end
	end

	assign option_price = option_q;
	assign status       = status_q;

endmodule

### design/bcop_ctrl.sv
// bcop_ctrl: sequencer for divide, leaf build and tree rollback
// depends on bcop_pkg; drives bcop_datapath through command and status structs
module bcop_ctrl #(
	parameter int MAX_STEPS = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	input  bcop_pkg::bcop_sts_t             sts,
	input  logic [$clog2(MAX_STEPS+1)-1:0]  t_steps,
	output bcop_pkg::bcop_cmd_t             cmd,
	output logic [$clog2(MAX_STEPS+1)-1:0]  addr
);
	import bcop_pkg::*;

	localparam int AW = $clog2(MAX_STEPS + 1);

	localparam logic [4:0] ST_IDLE      = 5'd0;
	localparam logic [4:0] ST_CHK       = 5'd1;
	localparam logic [4:0] ST_DIVP      = 5'd2;
	localparam logic [4:0] ST_LEAF_INIT = 5'd3;
	localparam logic [4:0] ST_LEAF_MUL  = 5'd4;
	localparam logic [4:0] ST_LEAF_UPD  = 5'd5;
	localparam logic [4:0] ST_LEAF_WR   = 5'd6;
	localparam logic [4:0] ST_RB_ROW    = 5'd7;
	localparam logic [4:0] ST_RB_LO     = 5'd8;
	localparam logic [4:0] ST_RB_RDA    = 5'd9;
	localparam logic [4:0] ST_RB_HI     = 5'd10;
	localparam logic [4:0] ST_RB_MP     = 5'd11;
	localparam logic [4:0] ST_RB_MQ     = 5'd12;
	localparam logic [4:0] ST_RB_SUM    = 5'd13;
	localparam logic [4:0] ST_RB_CHK    = 5'd14;
	localparam logic [4:0] ST_RB_DIV    = 5'd15;
	localparam logic [4:0] ST_RB_WR     = 5'd16;
	localparam logic [4:0] ST_FIN       = 5'd17;
	localparam logic [4:0] ST_DONE      = 5'd18;

	logic [4:0]    state_q, state_d;
	logic [AW-1:0] i_q, i_d, j_q, j_d, n_q, n_d;
	logic          mvalid_q;
	logic [AW-1:0] i_inc;
	logic          slot_free;

	assign i_inc     = i_q + AW'(1);
	assign slot_free = !mvalid_q || m_tready;

	// next state and commands
	always_comb begin
		state_d = state_q;
		i_d     = i_q;
		j_d     = j_q;
		n_d     = n_q;
		cmd     = '0;
		addr    = '0;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_CHK;
				end
			end
			ST_CHK: begin
				if (sts.invalid) begin
					state_d = ST_DONE;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_mode  = DIV_P;
					state_d       = ST_DIVP;
				end
			end
			ST_DIVP: begin
				if (sts.div_done) begin
					cmd.p_load = 1'b1;
					i_d        = '0;
					state_d    = ST_LEAF_INIT;
				end
			end
			ST_LEAF_INIT: begin
				cmd.s_init = 1'b1;
				j_d        = '0;
				state_d    = ST_LEAF_MUL;
			end
			ST_LEAF_MUL: begin
				if (j_q == t_steps) begin
					state_d = ST_LEAF_WR;
				end else begin
					cmd.mul_go  = 1'b1;
					// down moves first, then up moves
					cmd.mul_sel = (({1'b0, j_q} + {1'b0, i_q}) < {1'b0, t_steps}) ?
						MUL_DOWN : MUL_UP;
					state_d     = ST_LEAF_UPD;
				end
			end
			ST_LEAF_UPD: begin
				cmd.s_update = 1'b1;
				j_d          = j_q + AW'(1);
				state_d      = ST_LEAF_MUL;
			end
			ST_LEAF_WR: begin
				cmd.mem_we    = 1'b1;
				cmd.wr_payoff = 1'b1;
				addr          = i_q;
				if (i_q == t_steps) begin
					n_d     = t_steps;
					i_d     = '0;
					state_d = (t_steps == '0) ? ST_FIN : ST_RB_ROW;
				end else begin
					i_d     = i_inc;
					state_d = ST_LEAF_INIT;
				end
			end
			ST_RB_ROW: begin
				addr    = '0;
				state_d = ST_RB_LO;
			end
			ST_RB_LO: begin
				cmd.lo_load = 1'b1;
				state_d     = ST_RB_RDA;
			end
			ST_RB_RDA: begin
				addr    = i_inc;
				state_d = ST_RB_HI;
			end
			ST_RB_HI: begin
				cmd.hi_load = 1'b1;
				state_d     = ST_RB_MP;
			end
			ST_RB_MP: begin
				cmd.mul_go  = 1'b1;
				cmd.mul_sel = MUL_P;
				state_d     = ST_RB_MQ;
			end
			ST_RB_MQ: begin
				cmd.t1_load = 1'b1;
				cmd.mul_go  = 1'b1;
				cmd.mul_sel = MUL_Q;
				state_d     = ST_RB_SUM;
			end
			ST_RB_SUM: begin
				cmd.sum_load = 1'b1;
				state_d      = ST_RB_CHK;
			end
			ST_RB_CHK: begin
				if (sts.need_div) begin
					cmd.div_start = 1'b1;
					cmd.div_mode  = DIV_NODE;
					state_d       = ST_RB_DIV;
				end else begin
					cmd.node_fix = 1'b1;
					state_d      = ST_RB_WR;
				end
			end
			ST_RB_DIV: begin
				cmd.div_mode = DIV_NODE;
				if (sts.div_done) begin
					cmd.node_quot = 1'b1;
					state_d       = ST_RB_WR;
				end
			end
			ST_RB_WR: begin
				cmd.mem_we   = 1'b1;
				cmd.lo_shift = 1'b1;
				addr         = i_q;
				if (i_inc == n_q) begin
					n_d     = n_q - AW'(1);
					i_d     = '0;
					state_d = (n_q == AW'(1)) ? ST_FIN : ST_RB_ROW;
				end else begin
					i_d     = i_inc;
					state_d = ST_RB_RDA;
				end
			end
			ST_FIN: begin
				addr    = '0;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				addr = '0;
				if (slot_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state, counters and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			i_q      <= '0;
			j_q      <= '0;
			n_q      <= '0;
			mvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			i_q     <= i_d;
			j_q     <= j_d;
			n_q     <= n_d;
			if (cmd.out_load)
				mvalid_q <= 1'b1;
			else if (m_tready)
				mvalid_q <= 1'b0;
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = mvalid_q;

endmodule

### design/binomial_call_option_pricer_top.sv
// binomial_call_option_pricer_top: stream-facing top level of the call pricer
// depends on bcop_pkg, bcop_ctrl and bcop_datapath
//
// Prices a European call on a Cox-Ross-Rubinstein tree in fixed point: prices are
// unsigned Q16.16, rates signed Q1.30. One item is worked at a time; a new item is
// taken while the previous result still waits on the output. The divide for p comes
// first, then the leaf build with T steps runs T chained products per leaf through the
// one shared 32x32 multiplier, and a rolled-back node normally goes through the
// bit-serial divider for the 1+r discount; a node whose weighted sum is not positive,
// whose discount 1+r is zero, or whose quotient would overflow, skips the divider.
// An up rate not above the down rate gives a price of zero with status set. The node
// store holds MAX_STEPS+1 words and needs no clearing after reset.
module binomial_call_option_pricer_top #(
	parameter int MAX_STEPS = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration writes
	input  logic                           cfg_we,
	input  logic [bcop_pkg::CFG_AW-1:0]    cfg_addr,
	input  logic [bcop_pkg::RATE_W-1:0]    cfg_data,
	// input items
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [63:0]                    s_tdata,  // spot_price, strike_price
	// result items
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [31:0]                    m_tdata,  // option_price
	output logic [0:0]                     m_tuser   // status
);
	import bcop_pkg::*;

	localparam int AW = $clog2(MAX_STEPS + 1);

	bcop_cmd_t     cmd;
	bcop_sts_t     sts;
	logic [AW-1:0] addr;
	logic [AW-1:0] t_steps;
	logic          status_bit;

	bcop_ctrl #(
		.MAX_STEPS (MAX_STEPS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.t_steps  (t_steps),
		.cmd      (cmd),
		.addr     (addr)
	);

	bcop_datapath #(
		.MAX_STEPS (MAX_STEPS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_data     (cfg_data),
		.in_data      (s_tdata),
		.cmd          (cmd),
		.addr         (addr),
		.sts          (sts),
		.t_steps      (t_steps),
		.option_price (m_tdata),
		.status       (status_bit)
	);

	assign m_tuser = status_bit;

endmodule

### tb/bcop_checker.sv
// bcop_checker: watches the configuration port and both item channels of the call pricer,
// predicts each result on its own copy of the tree settings and compares field by field
// depends on bcop_pkg for the register indexes and port widths
module bcop_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [bcop_pkg::CFG_AW-1:0]  cfg_addr,
	input  logic [bcop_pkg::RATE_W-1:0]  cfg_data,
	input  logic                         s_tvalid,
	input  logic                         s_tready,
	input  logic [63:0]                  s_tdata,
	input  logic                         m_tvalid,
	input  logic                         m_tready,
	input  logic [31:0]                  m_tdata,
	input  logic [0:0]                   m_tuser,
	output int                           fail_cnt,
	output int                           pending_cnt
);
	import bcop_pkg::*;

	localparam logic STATUS_OK       = 1'b0;
	localparam logic STATUS_BAD_TREE = 1'b1;
	localparam longint ONE_Q30 = 64'sd1 << 30;
	localparam longint unsigned PRICE_TOP = 64'hFFFF_FFFF;
	localparam int TREE_MAX = 64;

	typedef struct {
		logic [31:0] price;
		logic        status;
	} call_quote_t;

	call_quote_t quote_q[$];

	// shadow copy of the tree settings
	longint      up_q, down_q, rate_q;
	int unsigned steps_q;
	longint unsigned tree[0:TREE_MAX];

	// price times a nonnegative Q2.30 factor, truncated and saturated
	function automatic longint unsigned grow(longint unsigned v, longint unsigned f);
		longint unsigned prod;
		prod = (v * f) >> 30;
		return (prod > PRICE_TOP) ? PRICE_TOP : prod;
	endfunction

	// signed Q2.30 weight times a price, truncated toward zero
	function automatic longint weight(longint w, longint unsigned c);
		longint unsigned mag, prod;
		mag  = (w < 0) ? longint'(-w) : longint'(w);
		prod = (mag * c) >> 30;
		return (w < 0) ? -longint'(prod) : longint'(prod);
	endfunction

	function automatic call_quote_t price_call(longint unsigned s0, longint unsigned k);
		call_quote_t res;
		longint p, q, g, sum;
		longint unsigned s, su, v;
		int unsigned t;
		res.price  = '0;
		res.status = STATUS_OK;
		if (up_q <= down_q) begin
			res.status = STATUS_BAD_TREE;
			return res;
		end
		t = (steps_q > TREE_MAX) ? TREE_MAX : steps_q;
		p = ((rate_q - down_q) * ONE_Q30) / (up_q - down_q);
		if (p > 64'sd2147483647) p = 64'sd2147483647;
		if (p < -64'sd2147483648) p = -64'sd2147483648;
		q = ONE_Q30 - p;
		g = ONE_Q30 + rate_q;
		// leaf payoffs
		for (int i = 0; i <= t; i++) begin
			s = s0;
			for (int j = 0; j < t - i; j++) s = grow(s, longint'(ONE_Q30 + down_q));
			for (int j = 0; j < i; j++) s = grow(s, longint'(ONE_Q30 + up_q));
			tree[i] = (s > k) ? s - k : 0;
		end
		// roll back to the root
		for (int n = t; n > 0; n--) begin
			for (int i = 0; i < n; i++) begin
				sum = weight(p, tree[i+1]) + weight(q, tree[i]);
				if (sum <= 0) v = 0;
				else if (g == 0) v = PRICE_TOP;
				else begin
					su = longint'(sum);
					if (su > 64'h1_FFFF_FFFF) su = 64'h1_FFFF_FFFF;
					v = (su << 30) / longint'(g);
					if (v > PRICE_TOP) v = PRICE_TOP;
				end
				tree[i] = v;
			end
		end
		res.price = tree[0][31:0];
		return res;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
		fail_cnt++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		call_quote_t want, got;
		if (!arst_n) begin
			up_q        <= longint'(UP_RST);
			down_q      <= longint'(DOWN_RST);
			rate_q      <= longint'(RATE_RST);
			steps_q     <= STEPS_RST;
			quote_q.delete();
			fail_cnt    = 0;
			pending_cnt <= 0;
		end else begin
			// register writes
			if (cfg_we) begin
				case (cfg_addr)
					CFG_UP:    up_q    <= longint'($signed(cfg_data));
					CFG_DOWN:  down_q  <= longint'($signed(cfg_data));
					CFG_RATE:  rate_q  <= longint'($signed(cfg_data));
					CFG_STEPS: steps_q <= cfg_data[STEP_W-1:0];
					default: ;
				endcase
			end
			// accepted input item
			if (s_tvalid && s_tready)
				quote_q = {quote_q, price_call(s_tdata[31:0], s_tdata[63:32])};
			// accepted result item
			if (m_tvalid && m_tready) begin
				got.price  = m_tdata;
				got.status = m_tuser[0];
				if (quote_q.size() == 0) begin
					$display("unexpected result at %0t: price %h status %b",
						$realtime, got.price, got.status);
					fail_cnt++;
				end else begin
					want = quote_q.pop_front();
					if (got.price !== want.price) report("option_price", got.price, want.price);
					if (got.status !== want.status)
						report("status", 32'(got.status), 32'(want.status));
				end
			end
			pending_cnt <= quote_q.size();
		end
	end

endmodule

### tb/testbench.sv
// testbench: stimulus, handshake idling and verdict for the binomial call option pricer
// depends on bcop_pkg, binomial_call_option_pricer_top and bcop_checker
module testbench;
	import bcop_pkg::*;

	localparam int STALL_LIMIT = 400000;
	localparam logic signed [RATE_W-1:0] RATE_MIN = -31'sd1073741824;
	localparam logic signed [RATE_W-1:0] RATE_TOP = 31'sd1073741823;
	localparam logic [31:0] P_MAX = 32'hFFFF_FFFF;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_AW-1:0]    cfg_addr = '0;
	logic [RATE_W-1:0]    cfg_data = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [63:0]          s_tdata = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [31:0]          m_tdata;
	logic [0:0]           m_tuser;
	int                   fail_cnt, pending_cnt;
	int                   send_idle_pct = 11, recv_stall_pct = 55;
	int                   items_sent = 0;
	int                   quiet_cycles = 0;

	always #1 clk = ~clk;

	binomial_call_option_pricer_top dut (.*);

	bcop_checker chk (.*);

	// receiver stalls
	always @(posedge clk) m_tready <= ($urandom_range(99) >= recv_stall_pct);

	// watchdog on cycles with no item moving
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic send_quote(logic [31:0] spot, logic [31:0] strike);
		// idle mix follows progress through the run
		if (items_sent < 50) begin
			send_idle_pct = 11; recv_stall_pct = 55;
		end else if (items_sent < 100) begin
			send_idle_pct = 55; recv_stall_pct = 11;
		end else begin
			send_idle_pct = 0; recv_stall_pct = 0;
		end
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {strike, spot};
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	// pause input until every result is back, then let the block settle
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_cnt != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic set_tree(logic signed [RATE_W-1:0] u, logic signed [RATE_W-1:0] d,
			logic signed [RATE_W-1:0] r, logic [STEP_W-1:0] t);
		drain();
		cfg_we <= 1'b1; cfg_addr <= CFG_UP; cfg_data <= u;
		@(posedge clk);
		cfg_addr <= CFG_DOWN; cfg_data <= d;
		@(posedge clk);
		cfg_addr <= CFG_RATE; cfg_data <= r;
		@(posedge clk);
		cfg_addr <= CFG_STEPS; cfg_data <= RATE_W'(t);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic signed [RATE_W-1:0] rand_rate();
		if ($urandom_range(3) == 0) return RATE_W'($urandom);
		return RATE_W'(int'($urandom_range(0, 1 << 27)) - (1 << 26));
	endfunction

	task automatic send_random();
		logic [31:0] spot, strike;
		if ($urandom_range(1) == 0) begin
			spot   = $urandom;
			strike = $urandom;
		end else begin
			spot   = $urandom_range(1 << 16, 200 << 16);
			strike = spot + $urandom_range(0, 40 << 16) - (20 << 16);
		end
		send_quote(spot, strike);
	endtask

	initial begin
		logic signed [RATE_W-1:0] u, d, r;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings, price extremes
		send_quote(0, 0);
		send_quote(P_MAX, 0);
		send_quote(P_MAX, P_MAX);
		send_quote(0, P_MAX);
		send_quote(100 << 16, 95 << 16);
		send_quote(100 << 16, 105 << 16);
		// zero steps: payoff of spot itself
		set_tree(UP_RST, DOWN_RST, RATE_RST, 0);
		send_quote(100 << 16, 90 << 16);
		send_quote(90 << 16, 100 << 16);
		send_quote(P_MAX, 0);
		// up rate not above down rate
		set_tree(DOWN_RST, DOWN_RST, RATE_RST, 2);
		send_quote(100 << 16, 90 << 16);
		set_tree(RATE_MIN, RATE_TOP, RATE_RST, 2);
		send_quote(100 << 16, 90 << 16);
		// interest rate of minus one
		set_tree(UP_RST, DOWN_RST, RATE_MIN, 2);
		send_quote(100 << 16, 90 << 16);
		send_quote(50 << 16, 90 << 16);
		// widest rates
		set_tree(RATE_TOP, RATE_MIN, RATE_TOP, 3);
		send_quote(P_MAX, 0);
		send_quote(1 << 16, 0);
		// deepest tree, and a step count beyond it
		set_tree(UP_RST, DOWN_RST, RATE_RST, 64);
		send_quote(100 << 16, 100 << 16);
		send_quote($urandom, $urandom);
		set_tree(UP_RST, DOWN_RST, RATE_RST, 127);
		send_quote(100 << 16, 98 << 16);

		// random settings with shallow trees
		while (items_sent < 130) begin
			u = rand_rate();
			d = rand_rate();
			r = rand_rate();
			if ($urandom_range(7) != 0 && u <= d) begin
				u = d; d = rand_rate(); u = (u > d) ? u : d;
				if (u == d) d = RATE_MIN;
				if (u == RATE_MIN) u = RATE_TOP;
			end
			set_tree(u, d, r, 7'($urandom_range(1, 6)));
			repeat ($urandom_range(5, 15)) send_random();
		end

		drain();
		if (fail_cnt == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
